// ===== design/pft_pkg.sv =====
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types, constants and the rotation build micro-op table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pft_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int ROT_FRAC_BITS = 16;

    localparam int ROT_W   = ROT_FRAC_BITS + 2;
    localparam int ANG_W   = 48;
    localparam int OFF_W   = 3 * COORD_WIDTH;
    localparam int CFG_W   = (ANG_W > OFF_W) ? ANG_W : OFF_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_ANG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_ANG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_OFF = 3'd3;

    // Q30 fixed point
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [15:0] QUARTER     = 16'd16384;

    // scratch RAM map
    localparam int          SCR_DEPTH = 64;
    localparam logic [5:0]  CYSP_ADDR = 6'd12;
    localparam logic [5:0]  SYSP_ADDR = 6'd13;
    localparam logic [5:0]  RC_BASE   = 6'd16;
    localparam logic [5:0]  RP_BASE   = 6'd32;
    localparam logic [3:0]  RPY_LAST  = 4'd14;

    typedef logic signed [ROT_W-1:0] t_rot_entry;
    typedef t_rot_entry [8:0]        t_rot;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mapped_x;
        logic signed [COORD_WIDTH-1:0] mapped_y;
        logic signed [COORD_WIDTH-1:0] mapped_z;
        logic                          saturated;
    } t_result;

    // one multiply-accumulate step of the matrix build
    typedef struct packed {
        logic [5:0] a;
        logic [5:0] b;
        logic       bone;   // b operand is 1.0
        logic       neg;    // subtract the product
        logic       first;  // start a new sum
        logic       wr;     // store sum to scratch
        logic       wc;     // store rounded sum to combined matrix
        logic [5:0] dst;
    } t_mop;

    function automatic logic [7:0] div_const(input logic [2:0] it);
        case (it)
            3'd0: div_const = 8'd156;
            3'd1: div_const = 8'd110;
            3'd2: div_const = 8'd72;
            3'd3: div_const = 8'd42;
            3'd4: div_const = 8'd20;
            default: div_const = 8'd6;
        endcase
    endfunction

    // floor(2^shift / k) with shift = 32 + floor(log2 k)
    function automatic logic [31:0] div_magic(input logic [2:0] it);
        case (it)
            3'd0: div_magic = 32'd3524075730;
            3'd1: div_magic = 32'd2498890063;
            3'd2: div_magic = 32'd3817748707;
            3'd3: div_magic = 32'd3272356035;
            3'd4: div_magic = 32'd3435973836;
            default: div_magic = 32'd2863311530;
        endcase
    endfunction

    function automatic logic [5:0] div_shift(input logic [2:0] it);
        case (it)
            3'd0: div_shift = 6'd39;
            3'd1: div_shift = 6'd38;
            3'd2: div_shift = 6'd38;
            3'd3: div_shift = 6'd37;
            3'd4: div_shift = 6'd36;
            default: div_shift = 6'd34;
        endcase
    endfunction

    // R = Rz(yaw) * Ry(pitch) * Rx(roll); sines at 0..5, cosines at 6..11
    function automatic t_mop rpy_op(input logic frm, input logic [3:0] n);
        t_mop       op;
        logic [5:0] s;
        logic [5:0] c;
        logic [5:0] m;
        s  = frm ? 6'd3 : 6'd0;
        c  = s + 6'd6;
        m  = frm ? RP_BASE : RC_BASE;
        op = '0;
        case (n)
            4'd0: begin
                op.a = c + 6'd2; op.b = s + 6'd1; op.first = 1'b1;
                op.wr = 1'b1; op.dst = CYSP_ADDR;
            end
            4'd1: begin
                op.a = s + 6'd2; op.b = s + 6'd1; op.first = 1'b1;
                op.wr = 1'b1; op.dst = SYSP_ADDR;
            end
            4'd2: begin
                op.a = c + 6'd2; op.b = c + 6'd1; op.first = 1'b1;
                op.wr = 1'b1; op.dst = m;
            end
            4'd3: begin
                op.a = CYSP_ADDR; op.b = s; op.first = 1'b1;
            end
            4'd4: begin
                op.a = s + 6'd2; op.b = c; op.neg = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd1;
            end
            4'd5: begin
                op.a = CYSP_ADDR; op.b = c; op.first = 1'b1;
            end
            4'd6: begin
                op.a = s + 6'd2; op.b = s;
                op.wr = 1'b1; op.dst = m + 6'd2;
            end
            4'd7: begin
                op.a = s + 6'd2; op.b = c + 6'd1; op.first = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd3;
            end
            4'd8: begin
                op.a = SYSP_ADDR; op.b = s; op.first = 1'b1;
            end
            4'd9: begin
                op.a = c + 6'd2; op.b = c;
                op.wr = 1'b1; op.dst = m + 6'd4;
            end
            4'd10: begin
                op.a = SYSP_ADDR; op.b = c; op.first = 1'b1;
            end
            4'd11: begin
                op.a = c + 6'd2; op.b = s; op.neg = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd5;
            end
            4'd12: begin
                op.a = s + 6'd1; op.bone = 1'b1; op.first = 1'b1; op.neg = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd6;
            end
            4'd13: begin
                op.a = c + 6'd1; op.b = s; op.first = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd7;
            end
            4'd14: begin
                op.a = c + 6'd1; op.b = c; op.first = 1'b1;
                op.wr = 1'b1; op.dst = m + 6'd8;
            end
            default: ;
        endcase
        return op;
    endfunction

endpackage

// ===== design/pft_ram.sv =====
// ----------------------------------------------------------------------------
// pft_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr_a,
    input  logic [$clog2(D)-1:0] i_raddr_b,
    output logic [W-1:0]         o_rdata_a,
    output logic [W-1:0]         o_rdata_b
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== design/pft_rebuild.sv =====
// ----------------------------------------------------------------------------
// pft_rebuild
// Sequencer that rebuilds the combined rotation from both frames' angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_rebuild
    import pft_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ANG_W-1:0] i_child_ang,
    input  logic [ANG_W-1:0] i_parent_ang,
    output logic             o_busy,
    output t_rot             o_rot
);

    localparam int SH = 30 - ROT_FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_X_MUL, ST_X, ST_X2_MUL, ST_X2, ST_P_MUL, ST_P, ST_Q_MUL,
        ST_Q, ST_C, ST_S_MUL, ST_S, ST_M_RD, ST_M_MUL, ST_M_ACC
    } t_state;

    t_state r_state;
    logic        r_cos, r_frm;
    logic [1:0]  r_ax;
    logic [2:0]  r_it;
    logic [30:0] r_x, r_t;
    logic [31:0] r_x2, r_dvd, r_quo;
    logic signed [65:0] r_prod;
    logic        r_mphase, r_mf;
    logic [3:0]  r_mn;
    logic [1:0]  r_mi, r_mj, r_mk;
    logic signed [35:0] r_acc;
    t_rot        r_rot;

    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] m2;
        mag = v[65] ? 66'(-v) : v;
        m2  = (mag + (66'd1 << 29)) >> 30;
        rnd30 = v[65] ? -$signed(m2[35:0]) : $signed(m2[35:0]);
    endfunction

    function automatic logic signed [35:0] rndc(input logic signed [35:0] v);
        logic [35:0] mag;
        logic [35:0] m2;
        mag = v[35] ? 36'(-v) : v;
        m2  = (mag + (36'd1 << (SH - 1))) >> SH;
        rndc = v[35] ? -$signed(m2) : $signed(m2);
    endfunction

    // angle for the current sine/cosine evaluation
    logic [ANG_W-1:0] w_ang;
    logic [15:0]      w_u, w_u2;
    logic [14:0]      w_rr;
    logic [5:0]       w_sin_addr;

    always_comb begin
        w_ang = r_frm ? i_parent_ang : i_child_ang;
        case (r_ax)
            2'd0: w_u = w_ang[15:0];
            2'd1: w_u = w_ang[31:16];
            default: w_u = w_ang[47:32];
        endcase
        w_u2 = w_u + (r_cos ? QUARTER : 16'd0);
        w_rr = w_u2[14] ? (15'd16384 - {1'b0, w_u2[13:0]}) : {1'b0, w_u2[13:0]};
        w_sin_addr = (r_cos ? 6'd6 : 6'd0) + (r_frm ? 6'd3 : 6'd0) + {4'b0, r_ax};
    end

    // current matrix step
    t_mop w_op;
    always_comb begin
        if (!r_mphase) begin
            w_op = rpy_op(r_mf, r_mn);
        end else begin
            w_op       = '0;
            w_op.a     = RP_BASE + 6'({r_mi, 1'b0} + {1'b0, r_mi}) + {4'b0, r_mk};
            w_op.b     = RC_BASE + 6'({r_mj, 1'b0} + {1'b0, r_mj}) + {4'b0, r_mk};
            w_op.first = (r_mk == 2'd0);
            w_op.wc    = (r_mk == 2'd2);
            w_op.dst   = 6'({r_mi, 1'b0} + {1'b0, r_mi}) + {4'b0, r_mj};
        end
    end

    logic [31:0] w_rd_a, w_rd_b;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mul;

    always_comb begin
        case (r_state)
            ST_X_MUL: begin
                w_ma = $signed({18'b0, w_rr});
                w_mb = $signed({2'b0, HALF_PI_Q30});
            end
            ST_X2_MUL: begin
                w_ma = $signed({2'b0, r_x});
                w_mb = $signed({2'b0, r_x});
            end
            ST_P_MUL: begin
                w_ma = $signed({1'b0, r_x2});
                w_mb = $signed({2'b0, r_t});
            end
            ST_Q_MUL: begin
                w_ma = $signed({1'b0, r_dvd});
                w_mb = $signed({1'b0, div_magic(r_it)});
            end
            ST_S_MUL: begin
                w_ma = $signed({2'b0, r_x});
                w_mb = $signed({2'b0, r_t});
            end
            ST_M_MUL: begin
                w_ma = $signed({w_rd_a[31], w_rd_a});
                w_mb = w_op.bone ? $signed({2'b0, Q30_ONE}) : $signed({w_rd_b[31], w_rd_b});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_mul = w_ma * w_mb;
    end

    logic [65:0] w_x_sum, w_x2_sum;
    logic [7:0]  w_k;
    logic [65:0] w_qsh;
    logic [39:0] w_qk, w_rm;
    logic        w_fix;
    logic [31:0] w_quot;
    logic [31:0] w_sin_mag, w_sin_val;
    logic signed [35:0] w_term, n_acc, w_rnd;

    always_comb begin
        w_x_sum   = r_prod + 66'd8192;
        w_x2_sum  = r_prod + (66'd1 << 29);
        w_k       = div_const(r_it);
        // quotient estimate from the reciprocal, low by at most one
        w_qsh     = r_prod >> div_shift(r_it);
        w_qk      = 40'(r_quo) * 40'(w_k);
        w_rm      = 40'(r_dvd) - w_qk;
        w_fix     = (w_rm >= 40'(w_k));
        w_quot    = r_quo + {31'b0, w_fix};
        w_sin_mag = (r_prod[61:30] > {1'b0, Q30_ONE}) ? {1'b0, Q30_ONE} : r_prod[61:30];
        w_sin_val = w_u2[15] ? (32'd0 - w_sin_mag) : w_sin_mag;
        w_term    = w_op.neg ? -rnd30(r_prod) : rnd30(r_prod);
        n_acc     = (w_op.first ? 36'sd0 : r_acc) + w_term;
        w_rnd     = rndc(n_acc);
    end

    logic        w_we;
    logic [5:0]  w_waddr;
    logic [31:0] w_wdata;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_sin_addr;
        w_wdata = w_sin_val;
        if (r_state == ST_S) begin
            w_we = 1'b1;
        end else if (r_state == ST_M_ACC && w_op.wr) begin
            w_we    = 1'b1;
            w_waddr = w_op.dst;
            w_wdata = n_acc[31:0];
        end
    end

    pft_ram #(
        .W (32),
        .D (SCR_DEPTH)
    ) u_scratch (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_op.a),
        .i_raddr_b (w_op.b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        if (!i_rst_n || i_start) begin
            r_state  <= ST_X_MUL;
            r_cos    <= 1'b0;
            r_frm    <= 1'b0;
            r_ax     <= 2'd0;
            r_it     <= 3'd0;
            r_mphase <= 1'b0;
            r_mf     <= 1'b0;
            r_mn     <= 4'd0;
            r_mi     <= 2'd0;
            r_mj     <= 2'd0;
            r_mk     <= 2'd0;
        end else begin
            case (r_state)
                ST_X_MUL:  r_state <= ST_X;
                ST_X: begin
                    r_x     <= w_x_sum[44:14];
                    r_state <= ST_X2_MUL;
                end
                ST_X2_MUL: r_state <= ST_X2;
                ST_X2: begin
                    r_x2    <= w_x2_sum[61:30];
                    r_t     <= Q30_ONE;
                    r_it    <= 3'd0;
                    r_state <= ST_P_MUL;
                end
                ST_P_MUL:  r_state <= ST_P;
                ST_P: begin
                    r_dvd   <= r_prod[61:30];
                    r_state <= ST_Q_MUL;
                end
                ST_Q_MUL:  r_state <= ST_Q;
                ST_Q: begin
                    r_quo   <= w_qsh[31:0];
                    r_state <= ST_C;
                end
                ST_C: begin
                    r_t <= 31'({1'b0, Q30_ONE} - w_quot);
                    if (r_it == 3'd5) begin
                        r_state <= ST_S_MUL;
                    end else begin
                        r_it    <= r_it + 3'd1;
                        r_state <= ST_P_MUL;
                    end
                end
                ST_S_MUL:  r_state <= ST_S;
                ST_S: begin
                    r_state <= ST_X_MUL;
                    if (r_ax != 2'd2) begin
                        r_ax <= r_ax + 2'd1;
                    end else begin
                        r_ax <= 2'd0;
                        if (!r_frm) begin
                            r_frm <= 1'b1;
                        end else begin
                            r_frm <= 1'b0;
                            if (!r_cos) begin
                                r_cos <= 1'b1;
                            end else begin
                                r_state <= ST_M_RD;
                            end
                        end
                    end
                end
                ST_M_RD:   r_state <= ST_M_MUL;
                ST_M_MUL:  r_state <= ST_M_ACC;
                ST_M_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= ST_M_RD;
                    if (w_op.wc) begin
                        r_rot[w_op.dst[3:0]] <= w_rnd[ROT_W-1:0];
                    end
                    if (!r_mphase) begin
                        if (r_mn == RPY_LAST) begin
                            r_mn <= 4'd0;
                            if (r_mf) begin
                                r_mphase <= 1'b1;
                            end else begin
                                r_mf <= 1'b1;
                            end
                        end else begin
                            r_mn <= r_mn + 4'd1;
                        end
                    end else if (r_mk != 2'd2) begin
                        r_mk <= r_mk + 2'd1;
                    end else begin
                        r_mk <= 2'd0;
                        if (r_mj != 2'd2) begin
                            r_mj <= r_mj + 2'd1;
                        end else begin
                            r_mj <= 2'd0;
                            if (r_mi != 2'd2) begin
                                r_mi <= r_mi + 2'd1;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_rot  = r_rot;

endmodule

// ===== design/point_frame_transform_top.sv =====
// ----------------------------------------------------------------------------
// point_frame_transform_top: child-to-parent rigid transform of 3-D points.
// One point per cycle while the output is not stalled and no rotation
// rebuild runs. After reset or an angle write the rotation rebuild holds
// o_pt_ready low (shared multiplier, reciprocal divide); offsets none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_frame_transform_top
    import pft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pt_valid,
    output logic                 o_pt_ready,
    input  t_point               i_pt,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = ROT_W + DW;
    localparam int SW = PW + 2;
    localparam int MW = CW + 5;
    localparam int VW = CW + 6;

    logic [ANG_W-1:0] r_child_ang, r_parent_ang;
    logic [OFF_W-1:0] r_child_off, r_parent_off;

    logic w_ang_wr;
    assign w_ang_wr = i_cfg_we && (i_cfg_idx == CFG_CHILD_ANG || i_cfg_idx == CFG_PARENT_ANG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_ang  <= '0;
            r_child_off  <= '0;
            r_parent_ang <= '0;
            r_parent_off <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHILD_ANG:  r_child_ang  <= i_cfg_data[ANG_W-1:0];
                CFG_CHILD_OFF:  r_child_off  <= i_cfg_data[OFF_W-1:0];
                CFG_PARENT_ANG: r_parent_ang <= i_cfg_data[ANG_W-1:0];
                CFG_PARENT_OFF: r_parent_off <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_busy;
    t_rot w_rot;

    pft_rebuild u_rebuild (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_ang_wr),
        .i_child_ang  (r_child_ang),
        .i_parent_ang (r_parent_ang),
        .o_busy       (w_busy),
        .o_rot        (w_rot)
    );

    // point pipeline, all stages advance together
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [DW-1:0] r_d  [3];
    logic signed [PW-1:0] r_pr [9];
    logic signed [MW-1:0] r_m  [3];
    t_result              r_out;

    assign w_en       = !r_v4 || i_res_ready;
    assign o_pt_ready = w_en && !w_busy;

    logic signed [CW-1:0] w_p [3];
    logic signed [DW-1:0] n_d [3];
    logic signed [PW-1:0] n_pr [9];
    logic signed [SW-1:0] w_sum [3];
    logic [SW-1:0]        w_mag, w_mr;
    logic signed [MW-1:0] n_m [3];
    logic signed [VW-1:0] w_v [3];
    logic                 w_hi [3];
    logic                 w_lo [3];
    logic signed [CW-1:0] w_c [3];

    always_comb begin
        w_p[0] = i_pt.point_x;
        w_p[1] = i_pt.point_y;
        w_p[2] = i_pt.point_z;
        for (int k = 0; k < 3; k++) begin
            n_d[k] = DW'(w_p[k]) - DW'($signed(r_child_off[k*CW +: CW]));
        end
        for (int i = 0; i < 9; i++) begin
            n_pr[i] = PW'(w_rot[i]) * PW'(r_d[i % 3]);
        end
        w_mag = '0;
        w_mr  = '0;
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = SW'(r_pr[i*3]) + SW'(r_pr[i*3+1]) + SW'(r_pr[i*3+2]);
            w_mag    = w_sum[i][SW-1] ? SW'(-w_sum[i]) : w_sum[i];
            w_mr     = (w_mag + (SW'(1) << (ROT_FRAC_BITS - 1))) >> ROT_FRAC_BITS;
            n_m[i]   = w_sum[i][SW-1] ? -$signed(w_mr[MW-1:0]) : $signed(w_mr[MW-1:0]);
        end
        for (int i = 0; i < 3; i++) begin
            w_v[i]  = VW'(r_m[i]) + VW'($signed(r_parent_off[i*CW +: CW]));
            w_hi[i] = !w_v[i][VW-1] && (w_v[i][VW-2:CW-1] != '0);
            w_lo[i] = w_v[i][VW-1] && (w_v[i][VW-2:CW-1] != '1);
            if (w_hi[i]) begin
                w_c[i] = {1'b0, {(CW-1){1'b1}}};
            end else if (w_lo[i]) begin
                w_c[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                w_c[i] = w_v[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pt_valid && !w_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (w_en) begin
            r_d  <= n_d;
            r_pr <= n_pr;
            r_m  <= n_m;
            r_out.mapped_x  <= w_c[0];
            r_out.mapped_y  <= w_c[1];
            r_out.mapped_z  <= w_c[2];
            r_out.saturated <= w_hi[0] || w_lo[0] || w_hi[1] || w_lo[1] ||
                               w_hi[2] || w_lo[2];
        end
    end

    assign o_res_valid = r_v4;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    // an angle change blocks points until the rotation is rebuilt
    a_rebuild_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ang_wr |=> !o_pt_ready)
        else $error("point accepted during rotation rebuild");

    // a taken result with a bubble behind it leaves the output empty
    a_bubble_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && !r_v3) |=> !o_res_valid)
        else $error("result repeated");

    // a stall keeps the first stage occupied
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en) |=> r_v1)
        else $error("item lost in stall");
`endif

endmodule
